/* hw/rtl/rfs_pkg.sv */
// Shared types, constants and helper function of the ring FIFO with search.
package rfs_pkg;

  localparam int DEPTH     = 256;
  localparam int WORD_BITS = 32;
  localparam int SLOT_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = SLOT_BITS + 1;
  localparam int APB_BITS  = 32;
  localparam int PADDR_BITS = 2;

  localparam logic [PADDR_BITS-1:0] CAP_ADDR  = '0;
  localparam logic [CNT_BITS-1:0]   CAP_RESET = CNT_BITS'(DEPTH);

  typedef enum logic [2:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic                 we;
    logic [SLOT_BITS-1:0] waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [SLOT_BITS-1:0] raddr;
  } mem_req_t;

  function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] p,
                                                     input logic [CNT_BITS-1:0]  cap);
    logic [CNT_BITS-1:0] s;
    s = {1'b0, p} + CNT_BITS'(1);
    return (s >= cap) ? '0 : s[SLOT_BITS-1:0];
  endfunction

endpackage

/* hw/rtl/ring_fifo_with_search_unit.sv */
// Top level of the ring FIFO with search: APB capacity register, sequencer and ring memory.
//
// An item (opcode, value) is taken at a rising edge where start is high and busy is low.
// Each item yields one result beat on status, data, slot, count, full_res and empty_res,
// marked by done for exactly one cycle; the receiver cannot stall and must take it then.
// Enqueue, clear, unknown opcodes and any item refused on a full or empty queue return
// their beat in the cycle after the item is taken and leave busy low, so such items run
// one per cycle.
// Dequeue and peek first wait in the read state on the registered read of the ring
// memory, and done follows in the next cycle.
// Search walks the ring from the oldest word, one entry per cycle through the single
// memory read port and one shared comparator, and stops at the first match or after
// the newest word; busy is high meanwhile.
// The capacity register sits at byte address 0 of the APB port; writing it empties
// the queue. Configure only while the block is idle.
// After reset the queue is empty and the capacity is 256; the ring memory needs no
// clearing pass, since only written slots are ever read.
module ring_fifo_with_search_unit
  import rfs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  opcode,
  input  logic signed [WORD_BITS-1:0] value,
  output logic                        done,
  output logic                        status,
  output logic signed [WORD_BITS-1:0] data,
  output logic [SLOT_BITS-1:0]        slot,
  output logic [CNT_BITS-1:0]         count,
  output logic                        full_res,
  output logic                        empty_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [PADDR_BITS-1:0]       paddr,
  input  logic [APB_BITS-1:0]         pwdata,
  output logic [APB_BITS-1:0]         prdata,
  output logic                        pready
);

  logic [CNT_BITS-1:0]  cap_reg;
  logic [CNT_BITS-1:0]  eff_cap;
  logic                 cfg_clr;
  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] rdata;

  assign pready  = 1'b1;
  assign cfg_clr = psel && penable && pwrite && pready && (paddr == CAP_ADDR);
  assign prdata  = (paddr == CAP_ADDR) ? APB_BITS'(cap_reg) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
    end else if (cfg_clr) begin
      cap_reg <= pwdata[CNT_BITS-1:0];
    end
  end

  always_comb begin
    if (cap_reg == '0) begin
      eff_cap = CNT_BITS'(1);
    end else if (cap_reg > CAP_RESET) begin
      eff_cap = CAP_RESET;
    end else begin
      eff_cap = cap_reg;
    end
  end

  rfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .value     (value),
    .eff_cap   (eff_cap),
    .cfg_clr   (cfg_clr),
    .rdata     (rdata),
    .mem_req   (mem_req),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .data      (data),
    .slot      (slot),
    .count     (count),
    .full_res  (full_res),
    .empty_res (empty_res)
  );

  rfs_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("Result beat without an accepted item.");

  a_not_full_and_empty: assert property (@(posedge clk) disable iff (rst)
    done |-> !(full_res && empty_res))
    else $error("Result reports full and empty at once.");

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("Sequencer left idle without an accepted item.");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (count <= eff_cap))
    else $error("Count exceeds the capacity in use.");

endmodule

/* hw/rtl/rfs_mem.sv */
// Ring storage: one write port and one registered read port.
module rfs_mem
  import rfs_pkg::*;
(
  input  logic                 clk,
  input  mem_req_t             req,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

/* hw/rtl/rfs_ctrl.sv */
// Sequencer with pointers, count and the shared compare unit for search.
module rfs_ctrl
  import rfs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [2:0]                  opcode,
  input  logic signed [WORD_BITS-1:0] value,
  input  logic [CNT_BITS-1:0]         eff_cap,
  input  logic                        cfg_clr,
  input  logic [WORD_BITS-1:0]        rdata,
  output mem_req_t                    mem_req,
  output logic                        busy,
  output logic                        done,
  output logic                        status,
  output logic signed [WORD_BITS-1:0] data,
  output logic [SLOT_BITS-1:0]        slot,
  output logic [CNT_BITS-1:0]         count,
  output logic                        full_res,
  output logic                        empty_res
);

  state_t               state, state_next;
  logic [SLOT_BITS-1:0] head, head_next;
  logic [SLOT_BITS-1:0] tail, tail_next;
  logic [CNT_BITS-1:0]  held, held_next;
  logic [SLOT_BITS-1:0] cur, cur_next;
  logic [CNT_BITS-1:0]  remain, remain_next;
  logic [WORD_BITS-1:0] key, key_next;
  logic                 pop, pop_next;
  logic                 done_next, status_next, full_next, empty_next;
  logic [WORD_BITS-1:0] data_next;
  logic [SLOT_BITS-1:0] slot_next;
  logic [CNT_BITS-1:0]  count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      held  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      held  <= held_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    remain    <= remain_next;
    key       <= key_next;
    pop       <= pop_next;
    status    <= status_next;
    data      <= data_next;
    slot      <= slot_next;
    count     <= count_next;
    full_res  <= full_next;
    empty_res <= empty_next;
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    held_next     = held;
    cur_next      = cur;
    remain_next   = remain;
    key_next      = key;
    pop_next      = pop;
    done_next     = 1'b0;
    status_next   = status;
    data_next     = data;
    slot_next     = slot;
    mem_req.we    = 1'b0;
    mem_req.waddr = tail;
    mem_req.wdata = value;
    mem_req.raddr = head;

    case (state)
      ST_IDLE: begin
        if (start) begin
          done_next   = 1'b1;
          status_next = 1'b1;
          data_next   = '0;
          slot_next   = '0;
          case (opcode)
            OP_ENQ: begin
              if (held < eff_cap) begin
                mem_req.we  = 1'b1;
                tail_next   = slot_inc(tail, eff_cap);
                held_next   = held + CNT_BITS'(1);
                status_next = 1'b0;
              end
            end
            OP_DEQ, OP_PEEK: begin
              if (held != '0) begin
                done_next  = 1'b0;
                pop_next   = (opcode == OP_DEQ);
                state_next = ST_READ;
              end
            end
            OP_CLEAR: begin
              head_next   = '0;
              tail_next   = '0;
              held_next   = '0;
              status_next = 1'b0;
            end
            OP_SEARCH: begin
              if (held != '0) begin
                done_next   = 1'b0;
                key_next    = value;
                cur_next    = head;
                remain_next = held;
                state_next  = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        done_next   = 1'b1;
        status_next = 1'b0;
        data_next   = rdata;
        slot_next   = '0;
        if (pop) begin
          head_next = slot_inc(head, eff_cap);
          held_next = held - CNT_BITS'(1);
        end
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        mem_req.raddr = slot_inc(cur, eff_cap);
        if (rdata == key) begin
          done_next   = 1'b1;
          status_next = 1'b0;
          data_next   = '0;
          slot_next   = cur;
          state_next  = ST_IDLE;
        end else if (remain == CNT_BITS'(1)) begin
          done_next   = 1'b1;
          status_next = 1'b1;
          data_next   = '0;
          slot_next   = '0;
          state_next  = ST_IDLE;
        end else begin
          cur_next    = slot_inc(cur, eff_cap);
          remain_next = remain - CNT_BITS'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cfg_clr) begin
      head_next = '0;
      tail_next = '0;
      held_next = '0;
    end

    count_next = held_next;
    full_next  = (held_next == eff_cap);
    empty_next = (held_next == '0);
  end

endmodule
